FILE: rtl/hysteretic_resistance_mapping_defines.svh
// assertion macros for the hysteretic resistance mapping checker
`ifndef HYSTERETIC_RESISTANCE_MAPPING_DEFINES_SVH
`define HYSTERETIC_RESISTANCE_MAPPING_DEFINES_SVH

// antecedent holds now, consequent holds in the same cycle
`define HRM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hrm check failed");

// antecedent holds now, consequent holds in the next cycle
`define HRM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hrm check failed");

`endif

FILE: rtl/hrm_pkg.sv
// shared types, constants and helpers for the hysteretic resistance mapping
`timescale 1ns / 1ps
package hrm_pkg;

	localparam int VW    = 32;
	localparam int KW    = 36;
	localparam int OPW   = 40;
	localparam int PW    = 2 * OPW;
	localparam int QW    = 64;
	localparam int DEPTH = 16;
	localparam int IDXW  = $clog2(DEPTH);
	localparam int TABW  = 2;
	localparam int ADDRW = TABW + IDXW;
	localparam int CNTW  = 5;
	localparam int MCW   = $clog2(PW);

	localparam logic signed [QW-1:0]  QLIM   = 64'sh4000_0000_0000_0000;
	localparam logic signed [QW-1:0]  VMAX_W = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [QW-1:0]  VMIN_W = 64'shFFFF_FFFF_8000_0000;
	localparam logic signed [OPW-1:0] QONE   = 40'sd65536;

	// item functions
	localparam logic [1:0] FUNC_EVAL   = 2'd0;
	localparam logic [1:0] FUNC_WRITE  = 2'd1;
	localparam logic [1:0] FUNC_ORIGIN = 2'd2;

	// table codes
	localparam logic [TABW-1:0] TAB_PR = 2'd0;
	localparam logic [TABW-1:0] TAB_NR = 2'd1;
	localparam logic [TABW-1:0] TAB_PF = 2'd2;
	localparam logic [TABW-1:0] TAB_NF = 2'd3;

	// branch codes
	localparam logic [1:0] BR_LOAD   = 2'd0;
	localparam logic [1:0] BR_UNLOAD = 2'd1;
	localparam logic [1:0] BR_ORIGIN = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PR_POINTS = 2'd0;
	localparam logic [1:0] REG_NR_POINTS = 2'd1;
	localparam logic [1:0] REG_PF_POINTS = 2'd2;
	localparam logic [1:0] REG_NF_POINTS = 2'd3;

	// search modes
	localparam logic [1:0] MODE_INTERP = 2'd0;
	localparam logic [1:0] MODE_SLOPE  = 2'd1;
	localparam logic [1:0] MODE_STEP   = 2'd2;

	typedef struct packed {
		logic [1:0]            func;
		logic [1:0]            table_sel;
		logic [3:0]            point_index;
		logic signed [VW-1:0]  point_x;
		logic signed [VW-1:0]  point_y;
		logic signed [VW-1:0]  displacement;
		logic signed [VW-1:0]  displacement_step;
		logic signed [VW-1:0]  velocity;
	} in_t;

	typedef struct packed {
		logic signed [VW-1:0]  restoring_force;
		logic signed [VW-1:0]  tangent_stiffness;
		logic signed [VW-1:0]  load_mass_factor;
		logic signed [VW-1:0]  origin_now;
		logic [1:0]            branch;
		logic                  status;
	} out_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
	} point_t;

	typedef struct packed {
		logic             en;
		logic [ADDRW-1:0] addr;
		point_t           data;
	} mem_wr_t;

	typedef struct packed {
		logic                  start;
		logic signed [OPW-1:0] a;
		logic signed [OPW-1:0] b;
		logic signed [OPW-1:0] c;
	} md_req_t;

	typedef struct packed {
		logic                 done;
		logic                 dz;
		logic signed [QW-1:0] q;
	} md_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_X0, ST_DISP, ST_RD, ST_CHK, ST_MDGO, ST_MD,
		ST_RET, ST_SF, ST_OF1, ST_OF2, ST_OUT
	} st_t;

	typedef enum logic [3:0] {
		PH_CURVE, PH_SEG, PH_SFACT, PH_OFACT_U, PH_K0, PH_ORG,
		PH_K, PH_FORCE, PH_OFACT_V, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_DONE} md_st_t;

	// saturate a wide value to the result range
	function automatic logic signed [VW-1:0] sat_v(input logic signed [QW-1:0] v);
		if (v > VMAX_W) begin
			return VMAX_W[VW-1:0];
		end else if (v < VMIN_W) begin
			return VMIN_W[VW-1:0];
		end
		return v[VW-1:0];
	endfunction

	// clamp a point count register to the usable range
	function automatic logic [CNTW-1:0] eff_count(input logic [CNTW-1:0] r);
		if (r < CNTW'(2)) begin
			return CNTW'(2);
		end else if (r > CNTW'(DEPTH)) begin
			return CNTW'(DEPTH);
		end
		return r;
	endfunction

endpackage

FILE: rtl/hysteretic_resistance_mapping.sv
// top level: sequencer over the point table memory and the serial mul-div unit
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   in_data   (hrm_pkg::in_t)
//  out      output     out_valid / out_ready out_data  (hrm_pkg::out_t)
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// a write, origin or no-op item goes from idle straight to the output state, where
// its result is registered. an evaluation walks the tables one point at a time
// (memory read, then compare) and runs each a*b/c through the serial unit.
// one item is in flight at a time; a result held by out_ready stalls the next.
// reset clears control state and the origin; table contents stay unknown.
`timescale 1ns / 1ps
module hysteretic_resistance_mapping (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  hrm_pkg::in_t             in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output hrm_pkg::out_t            out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [hrm_pkg::CNTW-1:0] cfg_data
);

	localparam int KW  = hrm_pkg::KW;
	localparam int VW  = hrm_pkg::VW;
	localparam int OPW = hrm_pkg::OPW;
	localparam int QW  = hrm_pkg::QW;

	hrm_pkg::st_t     state_q, state_d;
	hrm_pkg::phase_t  phase_q, phase_nx;
	hrm_pkg::in_t     in_q;
	hrm_pkg::out_t    out_q;
	logic             out_valid_q;

	logic [hrm_pkg::CNTW-1:0] pr_pts_q, nr_pts_q, pf_pts_q, nf_pts_q;

	logic signed [VW-1:0]  origin_q, x0_q, force_q, slope_q, lmf_q, k_q, res_q;
	logic signed [KW-1:0]  u_q, key_q;
	logic [1:0]            branch_q, mode_q;
	logic                  above_q, dz_q, upper_q, hit1_q, neg_q;
	logic [hrm_pkg::TABW-1:0] tab_q;
	logic [hrm_pkg::IDXW-1:0] idx_q;
	hrm_pkg::point_t       prev_q;
	logic signed [QW-1:0]  base_q;
	logic signed [OPW-1:0] op_a_q, op_b_q, op_c_q;

	hrm_pkg::mem_wr_t         mem_wr;
	logic                     rd_en;
	logic [hrm_pkg::ADDRW-1:0] rd_addr;
	hrm_pkg::point_t          rd_data;
	hrm_pkg::md_req_t         md_req;
	hrm_pkg::md_rsp_t         md_rsp;

	logic                  in_xfer;
	logic signed [KW-1:0]  d_k, nxt_k, o_k, u_k, v_k;
	logic [hrm_pkg::CNTW-1:0] n_eff;
	logic                  hit, last;

	hrm_table_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	hrm_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// table point writes
	assign mem_wr.en   = in_xfer && in_data.func == hrm_pkg::FUNC_WRITE;
	assign mem_wr.addr = {in_data.table_sel, in_data.point_index};
	assign mem_wr.data = '{x: in_data.point_x, y: in_data.point_y};

	// mul-div request from operand registers
	assign md_req.start = (state_q == hrm_pkg::ST_MDGO);
	assign md_req.a     = op_a_q;
	assign md_req.b     = op_b_q;
	assign md_req.c     = op_c_q;

	// evaluation operands
	assign d_k   = KW'(in_q.displacement);
	assign o_k   = KW'(origin_q);
	assign nxt_k = d_k + KW'(in_q.displacement_step);
	assign u_k   = d_k - o_k + KW'(rd_data.x);
	assign v_k   = d_k - o_k;

	// search compare against the point just read
	always_comb begin
		case (tab_q)
			hrm_pkg::TAB_PR: n_eff = hrm_pkg::eff_count(pr_pts_q);
			hrm_pkg::TAB_NR: n_eff = hrm_pkg::eff_count(nr_pts_q);
			hrm_pkg::TAB_PF: n_eff = hrm_pkg::eff_count(pf_pts_q);
			default:         n_eff = hrm_pkg::eff_count(nf_pts_q);
		endcase
		hit  = hit1_q || (upper_q ? key_q < KW'(rd_data.x) : key_q > KW'(rd_data.x));
		last = {1'b0, idx_q} == n_eff - 1'b1;
	end

	// phase order per branch
	always_comb begin
		case (phase_q)
			hrm_pkg::PH_CURVE:   phase_nx = (branch_q == hrm_pkg::BR_UNLOAD)
				? hrm_pkg::PH_K0 : hrm_pkg::PH_SEG;
			hrm_pkg::PH_SEG:     phase_nx = (branch_q == hrm_pkg::BR_LOAD)
				? hrm_pkg::PH_SFACT : hrm_pkg::PH_OFACT_U;
			hrm_pkg::PH_K0:      phase_nx = hrm_pkg::PH_ORG;
			hrm_pkg::PH_ORG:     phase_nx = hrm_pkg::PH_K;
			hrm_pkg::PH_K:       phase_nx = hrm_pkg::PH_FORCE;
			hrm_pkg::PH_FORCE:   phase_nx = hrm_pkg::PH_OFACT_V;
			default:             phase_nx = hrm_pkg::PH_DONE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory reads and ready
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = {tab_q, idx_q};
		in_ready = 1'b0;
		case (state_q)
			hrm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = 1'b1;
				rd_addr  = {hrm_pkg::TAB_PR, hrm_pkg::IDXW'(0)};
				if (in_valid) begin
					state_d = (in_data.func == hrm_pkg::FUNC_EVAL)
						? hrm_pkg::ST_X0 : hrm_pkg::ST_OUT;
				end
			end
			hrm_pkg::ST_X0: state_d = hrm_pkg::ST_DISP;
			hrm_pkg::ST_DISP: begin
				case (phase_q)
					hrm_pkg::PH_SFACT, hrm_pkg::PH_OFACT_U, hrm_pkg::PH_OFACT_V: begin
						rd_en   = 1'b1;
						rd_addr = {hrm_pkg::TAB_PF, hrm_pkg::IDXW'(0)};
						state_d = (phase_q == hrm_pkg::PH_SFACT)
							? hrm_pkg::ST_SF : hrm_pkg::ST_OF1;
					end
					hrm_pkg::PH_ORG, hrm_pkg::PH_FORCE: state_d = hrm_pkg::ST_MDGO;
					hrm_pkg::PH_DONE: state_d = hrm_pkg::ST_OUT;
					default: state_d = hrm_pkg::ST_RD;
				endcase
			end
			hrm_pkg::ST_SF: state_d = hrm_pkg::ST_RD;
			hrm_pkg::ST_RD: begin
				rd_en   = 1'b1;
				state_d = hrm_pkg::ST_CHK;
			end
			hrm_pkg::ST_CHK: begin
				if (idx_q == '0) begin
					state_d = hrm_pkg::ST_RD;
				end else if (hit) begin
					state_d = (mode_q == hrm_pkg::MODE_STEP)
						? hrm_pkg::ST_RET : hrm_pkg::ST_MDGO;
				end else if (last) begin
					state_d = hrm_pkg::ST_RET;
				end else begin
					state_d = hrm_pkg::ST_RD;
				end
			end
			hrm_pkg::ST_MDGO: state_d = hrm_pkg::ST_MD;
			hrm_pkg::ST_MD: begin
				if (md_rsp.done) begin
					state_d = hrm_pkg::ST_RET;
				end
			end
			hrm_pkg::ST_OF1: begin
				if (key_q > KW'(rd_data.x)) begin
					state_d = hrm_pkg::ST_RET;
				end else begin
					rd_en   = 1'b1;
					rd_addr = {hrm_pkg::TAB_NF, hrm_pkg::IDXW'(0)};
					state_d = hrm_pkg::ST_OF2;
				end
			end
			hrm_pkg::ST_OF2: state_d = hrm_pkg::ST_RET;
			hrm_pkg::ST_RET: state_d = hrm_pkg::ST_DISP;
			hrm_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = hrm_pkg::ST_IDLE;
				end
			end
			default: state_d = hrm_pkg::ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_pts_q <= hrm_pkg::CNTW'(2);
			nr_pts_q <= hrm_pkg::CNTW'(2);
			pf_pts_q <= hrm_pkg::CNTW'(2);
			nf_pts_q <= hrm_pkg::CNTW'(2);
		end else if (cfg_valid) begin
			case (cfg_index)
				hrm_pkg::REG_PR_POINTS: pr_pts_q <= cfg_data;
				hrm_pkg::REG_NR_POINTS: nr_pts_q <= cfg_data;
				hrm_pkg::REG_PF_POINTS: pf_pts_q <= cfg_data;
				hrm_pkg::REG_NF_POINTS: nf_pts_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// origin and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer && in_data.func == hrm_pkg::FUNC_ORIGIN) begin
				origin_q <= in_data.displacement;
			end else if (state_q == hrm_pkg::ST_RET && phase_q == hrm_pkg::PH_ORG) begin
				origin_q <= res_q;
			end
			if (state_q == hrm_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == hrm_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
			out_q.restoring_force   <= force_q;
			out_q.tangent_stiffness <= slope_q;
			out_q.load_mass_factor  <= lmf_q;
			out_q.origin_now        <= origin_q;
			out_q.branch            <= branch_q;
			out_q.status            <= dz_q;
		end
	end

	// evaluation datapath
	always_ff @(posedge clk) begin
		case (state_q)
			hrm_pkg::ST_IDLE: begin
				if (in_xfer) begin
					in_q     <= in_data;
					force_q  <= '0;
					slope_q  <= '0;
					lmf_q    <= '0;
					branch_q <= hrm_pkg::BR_LOAD;
					dz_q     <= 1'b0;
				end
			end
			hrm_pkg::ST_X0: begin
				x0_q    <= rd_data.x;
				u_q     <= u_k;
				above_q <= nxt_k > o_k;
				phase_q <= hrm_pkg::PH_CURVE;
				if ((nxt_k > o_k && in_q.velocity > 0) || (nxt_k < o_k && in_q.velocity < 0)) begin
					branch_q <= hrm_pkg::BR_LOAD;
				end else if (nxt_k != o_k) begin
					branch_q <= hrm_pkg::BR_UNLOAD;
				end else begin
					branch_q <= hrm_pkg::BR_ORIGIN;
				end
			end
			hrm_pkg::ST_DISP: begin
				idx_q  <= '0;
				hit1_q <= 1'b0;
				key_q  <= u_q;
				case (phase_q)
					hrm_pkg::PH_CURVE: begin
						upper_q <= u_q > KW'(x0_q);
						tab_q   <= (u_q > KW'(x0_q)) ? hrm_pkg::TAB_PR : hrm_pkg::TAB_NR;
						mode_q  <= hrm_pkg::MODE_INTERP;
					end
					hrm_pkg::PH_SEG: begin
						upper_q <= u_q > 0;
						tab_q   <= (u_q > 0) ? hrm_pkg::TAB_PR : hrm_pkg::TAB_NR;
						mode_q  <= hrm_pkg::MODE_SLOPE;
					end
					hrm_pkg::PH_K0: begin
						hit1_q <= 1'b1;
						tab_q  <= (u_q > KW'(x0_q)) ? hrm_pkg::TAB_PR : hrm_pkg::TAB_NR;
						mode_q <= hrm_pkg::MODE_SLOPE;
					end
					hrm_pkg::PH_K: begin
						hit1_q <= 1'b1;
						tab_q  <= (v_k > KW'(x0_q)) ? hrm_pkg::TAB_PR : hrm_pkg::TAB_NR;
						mode_q <= hrm_pkg::MODE_SLOPE;
					end
					hrm_pkg::PH_OFACT_V: begin
						key_q <= above_q ? v_k + KW'(x0_q) : v_k;
					end
					hrm_pkg::PH_ORG: begin
						op_a_q <= OPW'(force_q);
						op_b_q <= hrm_pkg::QONE;
						op_c_q <= OPW'(slope_q);
						base_q <= QW'(in_q.displacement);
						neg_q  <= 1'b1;
					end
					hrm_pkg::PH_FORCE: begin
						op_a_q <= OPW'(k_q);
						op_b_q <= OPW'(v_k);
						op_c_q <= hrm_pkg::QONE;
						base_q <= '0;
						neg_q  <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			hrm_pkg::ST_SF: begin
				idx_q   <= '0;
				hit1_q  <= 1'b0;
				mode_q  <= hrm_pkg::MODE_STEP;
				upper_q <= key_q > KW'(rd_data.x);
				tab_q   <= (key_q > KW'(rd_data.x)) ? hrm_pkg::TAB_PF : hrm_pkg::TAB_NF;
			end
			hrm_pkg::ST_CHK: begin
				if (idx_q == '0 || (!hit && !last)) begin
					prev_q <= rd_data;
					idx_q  <= idx_q + 1'b1;
				end else if (hit) begin
					res_q  <= rd_data.y;
					op_a_q <= OPW'(rd_data.y) - OPW'(prev_q.y);
					op_c_q <= OPW'(rd_data.x) - OPW'(prev_q.x);
					neg_q  <= 1'b0;
					if (mode_q == hrm_pkg::MODE_SLOPE) begin
						op_b_q <= hrm_pkg::QONE;
						base_q <= '0;
					end else begin
						op_b_q <= OPW'(key_q) - OPW'(prev_q.x);
						base_q <= QW'(prev_q.y);
					end
				end else begin
					res_q <= '0;
				end
			end
			hrm_pkg::ST_MD: begin
				if (md_rsp.done) begin
					res_q <= hrm_pkg::sat_v(neg_q ? base_q - md_rsp.q : base_q + md_rsp.q);
					dz_q  <= dz_q | md_rsp.dz;
				end
			end
			hrm_pkg::ST_OF1: begin
				res_q <= rd_data.y;
			end
			hrm_pkg::ST_OF2: begin
				res_q <= rd_data.y;
			end
			hrm_pkg::ST_RET: begin
				phase_q <= phase_nx;
				case (phase_q)
					hrm_pkg::PH_CURVE, hrm_pkg::PH_FORCE: force_q <= res_q;
					hrm_pkg::PH_SEG, hrm_pkg::PH_K0:      slope_q <= res_q;
					hrm_pkg::PH_K:                        k_q     <= res_q;
					hrm_pkg::PH_SFACT, hrm_pkg::PH_OFACT_U, hrm_pkg::PH_OFACT_V:
						lmf_q <= res_q;
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/hrm_table_mem.sv
// point table memory: all four tables, one write and one registered read port
`timescale 1ns / 1ps
module hrm_table_mem (
	input  logic                        clk,
	input  hrm_pkg::mem_wr_t            wr,
	input  logic                        rd_en,
	input  logic [hrm_pkg::ADDRW-1:0]   rd_addr,
	output hrm_pkg::point_t             rd_data
);

	hrm_pkg::point_t mem [2**hrm_pkg::ADDRW];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/hrm_muldiv.sv
// serial a*b/c unit: shift-add multiply then restoring divide, saturated
`timescale 1ns / 1ps
module hrm_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  hrm_pkg::md_req_t  req,
	output hrm_pkg::md_rsp_t  rsp
);

	hrm_pkg::md_st_t             st_q;
	logic [hrm_pkg::MCW-1:0]     cnt_q;
	logic [hrm_pkg::PW-1:0]      prod_q;
	logic [hrm_pkg::OPW-1:0]     ua_q;
	logic [hrm_pkg::OPW-1:0]     uc_q;
	logic [hrm_pkg::OPW:0]       rem_q;
	logic                        neg_q;
	logic                        dz_q;

	logic [hrm_pkg::OPW-1:0]     ua, ub, uc;
	logic [hrm_pkg::OPW:0]       msum;
	logic [hrm_pkg::OPW:0]       trem;
	logic                        tge;
	logic [hrm_pkg::QW-1:0]      qmag;

	// operand magnitudes
	assign ua = req.a[hrm_pkg::OPW-1] ? hrm_pkg::OPW'(-req.a) : hrm_pkg::OPW'(req.a);
	assign ub = req.b[hrm_pkg::OPW-1] ? hrm_pkg::OPW'(-req.b) : hrm_pkg::OPW'(req.b);
	assign uc = req.c[hrm_pkg::OPW-1] ? hrm_pkg::OPW'(-req.c) : hrm_pkg::OPW'(req.c);

	// one multiply step and one divide step
	assign msum = {1'b0, prod_q[hrm_pkg::PW-1:hrm_pkg::OPW]}
		+ (prod_q[0] ? {1'b0, ua_q} : '0);
	assign trem = {rem_q[hrm_pkg::OPW-1:0], prod_q[hrm_pkg::PW-1]};
	assign tge  = trem >= {1'b0, uc_q};

	// clamp the quotient magnitude
	always_comb begin
		if (prod_q[hrm_pkg::PW-1:hrm_pkg::QW-1] != '0
			|| (prod_q[hrm_pkg::QW-2] && prod_q[hrm_pkg::QW-3:0] != '0)) begin
			qmag = hrm_pkg::QLIM;
		end else begin
			qmag = prod_q[hrm_pkg::QW-1:0];
		end
	end

	assign rsp.done = (st_q == hrm_pkg::MD_DONE);
	assign rsp.dz   = dz_q;
	assign rsp.q    = neg_q ? -$signed(qmag) : $signed(qmag);

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= hrm_pkg::MD_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				hrm_pkg::MD_IDLE: begin
					if (req.start) begin
						cnt_q <= '0;
						if (ua == '0 || ub == '0 || uc == '0) begin
							st_q <= hrm_pkg::MD_DONE;
						end else begin
							st_q <= hrm_pkg::MD_MUL;
						end
					end
				end
				hrm_pkg::MD_MUL: begin
					if (cnt_q == hrm_pkg::MCW'(hrm_pkg::OPW - 1)) begin
						cnt_q <= '0;
						st_q  <= hrm_pkg::MD_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				hrm_pkg::MD_DIV: begin
					if (cnt_q == hrm_pkg::MCW'(hrm_pkg::PW - 1)) begin
						st_q <= hrm_pkg::MD_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: st_q <= hrm_pkg::MD_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			hrm_pkg::MD_IDLE: begin
				if (req.start) begin
					ua_q  <= ua;
					uc_q  <= uc;
					rem_q <= '0;
					neg_q <= req.a[hrm_pkg::OPW-1] ^ req.b[hrm_pkg::OPW-1]
						^ req.c[hrm_pkg::OPW-1];
					if (ua == '0 || ub == '0) begin
						prod_q <= '0;
						dz_q   <= (uc == '0);
					end else if (uc == '0) begin
						prod_q <= hrm_pkg::PW'(hrm_pkg::QLIM);
						dz_q   <= 1'b1;
					end else begin
						prod_q <= {{hrm_pkg::OPW{1'b0}}, ub};
						dz_q   <= 1'b0;
					end
				end
			end
			hrm_pkg::MD_MUL: begin
				prod_q <= {msum, prod_q[hrm_pkg::OPW-1:1]};
			end
			hrm_pkg::MD_DIV: begin
				rem_q  <= tge ? trem - {1'b0, uc_q} : trem;
				prod_q <= {prod_q[hrm_pkg::PW-2:0], tge};
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/hrm_checker.sv
// port-level checks for the hysteretic resistance mapping, bound to the top level
`timescale 1ns / 1ps
`include "hysteretic_resistance_mapping_defines.svh"
module hrm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input hrm_pkg::out_t out_data,
	input logic          cfg_valid,
	input logic          cfg_ready
);

	// one item in flight: no transfer in the cycle after one
	`HRM_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// a waiting result holds
	`HRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// configuration writes never stall
	`HRM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

	// the reported branch is never the unused code 3
	`HRM_ASSERT_NOW(a_no_third_branch, out_valid, out_data.branch != 2'd3)

endmodule

bind hysteretic_resistance_mapping hrm_checker u_hrm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

FILE: verif/tb_hysteretic_resistance_mapping.sv
// self-checking testbench for the hysteretic resistance mapping block
`timescale 1ns / 1ps
module tb_hysteretic_resistance_mapping;
	import hrm_pkg::*;

	localparam logic [1:0] FUNC_NOP  = 2'd3;
	localparam longint     Q_ONE     = 65536;
	localparam int         N_ITEMS   = 1100;
	localparam int         LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [CNTW-1:0] cfg_data = '0;

	// shadow state of the block
	logic signed [VW-1:0] tab_x [4][DEPTH];
	logic signed [VW-1:0] tab_y [4][DEPTH];
	logic [CNTW-1:0] pts_reg [4];
	longint origin_reg;

	in_t pending_q[$];
	out_t result_q[$];
	int errors = 0;
	int queued = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit in_quiet = 0;
	bit out_quiet = 0;
	bit nv;
	longint base_x;

	hysteretic_resistance_mapping DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic int usable_pts(logic [CNTW-1:0] r);
		if (r < 2) return 2;
		if (r > DEPTH) return DEPTH;
		return int'(r);
	endfunction

	// a*b/c toward zero, saturated to the wide limit
	function automatic longint scaled_quot(longint a, longint b, longint c, inout bit dz);
		logic [127:0] prod;
		logic [127:0] quot;
		logic [127:0] lim;
		bit neg;
		lim = 128'(QLIM);
		if (a == 0 || b == 0) begin
			if (c == 0) dz = 1;
			return 0;
		end
		neg = (a < 0) != (b < 0);
		if (c == 0) begin
			dz = 1;
			return neg ? -QLIM : QLIM;
		end
		if (c < 0) neg = !neg;
		prod = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		quot = prod / 128'(c < 0 ? -c : c);
		if (quot > lim) quot = lim;
		return neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
	endfunction

	// walk one table for the segment holding u
	function automatic longint table_walk(int t, bit upper, longint u, logic [1:0] mode,
			inout bit dz);
		longint xi, xp, dy, dx;
		for (int i = 1; i < usable_pts(pts_reg[t]); i++) begin
			xi = tab_x[t][i];
			if (upper ? (u < xi) : (u > xi)) begin
				xp = tab_x[t][i-1];
				dy = longint'(tab_y[t][i]) - longint'(tab_y[t][i-1]);
				dx = xi - xp;
				if (mode == MODE_STEP) return tab_y[t][i];
				if (mode == MODE_SLOPE) return clamp32(scaled_quot(dy, Q_ONE, dx, dz));
				return clamp32(longint'(tab_y[t][i-1]) + scaled_quot(dy, u - xp, dx, dz));
			end
		end
		return 0;
	endfunction

	function automatic longint force_at(longint u, inout bit dz);
		if (u > longint'(tab_x[TAB_PR][0])) return table_walk(TAB_PR, 1, u, MODE_INTERP, dz);
		return table_walk(TAB_NR, 0, u, MODE_INTERP, dz);
	endfunction

	function automatic longint slope_at(longint u, inout bit dz);
		if (u > 0) return table_walk(TAB_PR, 1, u, MODE_SLOPE, dz);
		return table_walk(TAB_NR, 0, u, MODE_SLOPE, dz);
	endfunction

	function automatic longint start_slope(longint w, inout bit dz);
		int t;
		t = (w > longint'(tab_x[TAB_PR][0])) ? TAB_PR : TAB_NR;
		return clamp32(scaled_quot(longint'(tab_y[t][1]) - longint'(tab_y[t][0]), Q_ONE,
			longint'(tab_x[t][1]) - longint'(tab_x[t][0]), dz));
	endfunction

	function automatic longint step_lmf(longint u);
		bit ignored;
		ignored = 0;
		if (u > longint'(tab_x[TAB_PF][0])) return table_walk(TAB_PF, 1, u, MODE_STEP, ignored);
		return table_walk(TAB_NF, 0, u, MODE_STEP, ignored);
	endfunction

	function automatic longint rest_lmf(longint w);
		return (w > longint'(tab_x[TAB_PF][0])) ? tab_y[TAB_PF][0] : tab_y[TAB_NF][0];
	endfunction

	// expected result of one item; updates the shadow state
	function automatic out_t mapping_result(in_t it);
		out_t r;
		longint d, o, x0, nxt, u, f, k0, v, k, frc, slp, lmf;
		bit dz, above;
		logic [1:0] br;
		dz = 0;
		frc = 0;
		slp = 0;
		lmf = 0;
		br = BR_LOAD;
		case (it.func)
			FUNC_WRITE: begin
				tab_x[it.table_sel][it.point_index] = it.point_x;
				tab_y[it.table_sel][it.point_index] = it.point_y;
			end
			FUNC_ORIGIN: origin_reg = it.displacement;
			FUNC_EVAL: begin
				d = it.displacement;
				o = origin_reg;
				x0 = tab_x[TAB_PR][0];
				nxt = d + longint'(it.displacement_step);
				u = d - o + x0;
				above = nxt > o;
				if ((above && it.velocity > 0) || (nxt < o && it.velocity < 0)) begin
					frc = force_at(u, dz);
					slp = slope_at(u, dz);
					lmf = step_lmf(u);
					br = BR_LOAD;
				end else if (nxt != o) begin
					f = force_at(u, dz);
					k0 = start_slope(u, dz);
					origin_reg = clamp32(d - scaled_quot(f, Q_ONE, k0, dz));
					v = d - origin_reg;
					k = start_slope(v, dz);
					frc = clamp32(scaled_quot(k, v, Q_ONE, dz));
					slp = k0;
					lmf = rest_lmf(above ? v + x0 : v);
					br = BR_UNLOAD;
				end else begin
					frc = force_at(u, dz);
					slp = slope_at(u, dz);
					lmf = rest_lmf(u);
					br = BR_ORIGIN;
				end
			end
			default: ;
		endcase
		r.restoring_force = frc[VW-1:0];
		r.tangent_stiffness = slp[VW-1:0];
		r.load_mass_factor = lmf[VW-1:0];
		r.origin_now = origin_reg[VW-1:0];
		r.branch = br;
		r.status = dz;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// driver: offers pending items, predicts each accepted transfer
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left = 0;
		end else begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				result_q.push_back(mapping_result(in_data));
				nv = 0;
				gap_left = in_quiet ? 0 : $urandom_range(0, 6);
				if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() > 0) begin
					in_data <= pending_q.pop_front();
					nv = 1;
				end
			end
			in_valid <= nv;
		end
	end

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// monitor: checks each result transfer and stalls at random
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					want = result_q.pop_front();
					if (out_data.restoring_force !== want.restoring_force)
						report("restoring_force", out_data.restoring_force, want.restoring_force);
					if (out_data.tangent_stiffness !== want.tangent_stiffness)
						report("tangent_stiffness", out_data.tangent_stiffness,
							want.tangent_stiffness);
					if (out_data.load_mass_factor !== want.load_mass_factor)
						report("load_mass_factor", out_data.load_mass_factor,
							want.load_mass_factor);
					if (out_data.origin_now !== want.origin_now)
						report("origin_now", out_data.origin_now, want.origin_now);
					if (out_data.branch !== want.branch)
						report("branch", out_data.branch, want.branch);
					if (out_data.status !== want.status)
						report("status", out_data.status, want.status);
				end
				stall_left = out_quiet ? 0 : $urandom_range(0, 6);
				if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
			end
			// long hold-off so the block backs up into its input
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_item(logic [1:0] f, logic [1:0] sel, logic [3:0] idx, longint px,
			longint py, longint d, longint dd, longint vel);
		in_t it;
		it.func = f;
		it.table_sel = sel;
		it.point_index = idx;
		it.point_x = px[VW-1:0];
		it.point_y = py[VW-1:0];
		it.displacement = d[VW-1:0];
		it.displacement_step = dd[VW-1:0];
		it.velocity = vel[VW-1:0];
		pending_q.push_back(it);
		queued++;
	endtask

	function automatic longint spread(int span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic longint any32();
		return longint'($signed($urandom));
	endfunction

	task automatic wait_idle();
		while (pending_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CNTW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		pts_reg[idx] = val;
		cfg_valid <= 1'b0;
	endtask

	// tables grow away from the common start point; some are pure noise
	task automatic load_table(logic [1:0] t, bit shaped);
		longint x, y;
		int dir;
		dir = (t == TAB_PR || t == TAB_PF) ? 1 : -1;
		x = base_x;
		y = spread(32'h20000);
		for (int i = 0; i < DEPTH; i++) begin
			if (shaped) add_item(FUNC_WRITE, t, i, x, y, any32(), any32(), any32());
			else add_item(FUNC_WRITE, t, i, any32(), any32(), any32(), any32(), any32());
			x += dir * (($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 32'h30000));
			y += spread(32'h80000);
		end
	endtask

	function automatic logic [CNTW-1:0] pick_count();
		case ($urandom_range(0, 5))
			0: return 5'd0;
			1: return 5'd2;
			2: return 5'd16;
			3: return 5'd31;
			default: return $urandom_range(0, 31);
		endcase
	endfunction

	task automatic random_item();
		longint d, o;
		int k;
		k = $urandom_range(0, 99);
		d = base_x + spread(32'h600000);
		if (k < 4) begin
			add_item(FUNC_WRITE, $urandom_range(0, 3), $urandom_range(0, 15),
				base_x + spread(32'h400000), spread(32'h800000), any32(), any32(), any32());
		end else if (k < 8) begin
			add_item(FUNC_NOP, $urandom, $urandom, any32(), any32(), any32(), any32(),
				any32());
		end else if (k < 14) begin
			// new origin, then land exactly on it
			o = base_x + spread(32'h400000);
			add_item(FUNC_ORIGIN, $urandom, $urandom, any32(), any32(), o, any32(), any32());
			add_item(FUNC_EVAL, $urandom, $urandom, any32(), any32(), d, o - d, any32());
		end else if (k < 20) begin
			add_item(FUNC_EVAL, $urandom, $urandom, any32(), any32(), any32(), any32(),
				any32());
		end else begin
			add_item(FUNC_EVAL, $urandom, $urandom, any32(), any32(), d, spread(32'h100000),
				($urandom_range(0, 9) == 0) ? 0 : any32());
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		origin_reg = 0;
		for (int i = 0; i < 4; i++) pts_reg[i] = 5'd2;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// every store entry gets written before anything reads it
		base_x = 0;
		for (int t = 0; t < 4; t++) load_table(t, 1);
		wait_idle();
		write_reg(REG_PR_POINTS, 5'd16);
		write_reg(REG_NR_POINTS, 5'd16);
		write_reg(REG_PF_POINTS, 5'd16);
		write_reg(REG_NF_POINTS, 5'd16);

		// directed corners: extremes, no-op, ignored-field items, exact origin
		add_item(FUNC_NOP, TAB_NF, 4'd15, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff);
		add_item(FUNC_ORIGIN, TAB_PR, 0, 0, 0, 0, 0, 0);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, 5, -5, 1);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, 32'h10000, 0, 0);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, 32'h10000, 32'h1000, 32'h7fffffff);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, -32'sh10000, -32'sh1000, 32'h80000000);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, -1);
		add_item(FUNC_ORIGIN, TAB_PR, 0, 0, 0, 32'h80000000, 0, 0);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 1);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, 32'h80000000, 32'h80000000, -1);
		add_item(FUNC_ORIGIN, TAB_PR, 0, 0, 0, 32'h7fffffff, 0, 0);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, 32'h80000000, 32'h80000000, 1);
		add_item(FUNC_ORIGIN, TAB_PR, 0, 0, 0, 0, 0, 0);
		// flat start segment: zero divisor in the initial slope
		add_item(FUNC_WRITE, TAB_PR, 4'd1, 0, 32'h1234, 0, 0, 0);
		add_item(FUNC_WRITE, TAB_NR, 4'd1, 0, -32'sh1234, 0, 0, 0);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, 32'h8000, -32'sh10000, 1);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, -32'sh8000, 32'h1000, 1);
		add_item(FUNC_WRITE, TAB_PF, 4'd15, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
		add_item(FUNC_WRITE, TAB_NF, 4'd15, 32'h80000000, 32'h80000000, 0, 0, 0);
		add_item(FUNC_EVAL, TAB_PR, 0, 0, 0, 32'h7ffffff0, 1, 1);
		wait_idle();

		// phases of random content under changing point counts
		while (queued < N_ITEMS) begin
			write_reg(REG_PR_POINTS, pick_count());
			write_reg(REG_NR_POINTS, pick_count());
			write_reg(REG_PF_POINTS, pick_count());
			write_reg(REG_NF_POINTS, pick_count());
			base_x = spread(32'h40000);
			for (int t = 0; t < 4; t++)
				if ($urandom_range(0, 1) == 0) load_table(t, $urandom_range(0, 7) != 0);
			add_item(FUNC_ORIGIN, $urandom, $urandom, any32(), any32(),
				base_x + spread(32'h200000), any32(), any32());
			for (int n = 0; n < 70; n++) begin
				random_item();
				if (queued > N_ITEMS / 2 && hold_req == 0) hold_req = 1;
			end
			// let the block drain before touching the registers again
			wait_idle();
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
